// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mmt_pkg.sv
package mmt_pkg;

   // Geometry
   localparam int MAX_DIM    = 32;
   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int DIM_W      = 6;

   // Arithmetic widths: Q8.8 elements, Q21.16 sums
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int ACC_W      = 37;

   // Stream widths
   localparam int OP_W       = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   // Reset value of the dimension register
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

endpackage

// File: src/matrix_multiply_transposed_top.sv
// Dense square matrix multiply C = A x B, B held transposed.
//
// Request channel (req_*): tuser carries the operation, tdata the row,
// column and value. Load A / load B transfers write one element each.
// A compute transfer names result row i; the block
// then streams dim result transfers on the response channel (rsp_*),
// C[i][0] .. C[i][dim-1], with tlast on the final one.
// Each result is one dot product on a single shared multiply-accumulate
// fed by two element memories read in linear order.
// req_tready is low for the whole row compute.
// The csr port writes the dimension at any edge; write it only while
// idle. A row in progress keeps the dimension it started with.
// Reset sets dim to 32 and empties the pipeline; element memories hold
// no reset value and must be loaded before use.
// A stalled response holds the result in the output register; the MAC
// stops before overwriting it and resumes once the transfer completes.
`include "assert_macros.svh"

module matrix_multiply_transposed_top (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [mmt_pkg::DIM_W-1:0]        csr_wr_data,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] row, [9:5] col, [25:10] value, [31:26] zero
   input  logic [mmt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  logic [mmt_pkg::OP_W-1:0]         req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [4:0] out_row, [9:5] out_col, [46:10] product_value, [47] zero
   output logic [mmt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import mmt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   // request fields
   logic [IDX_W-1:0] req_row;
   logic [IDX_W-1:0] req_col;
   elem_type         req_value;
   logic             req_xfer;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
   assign req_xfer  = req_tvalid && req_tready;

   // configuration
   logic [DIM_W-1:0] dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   // last valid index: dim 0 acts as 1, above MAX_DIM clamps
   logic [IDX_W-1:0] last_idx_in;

   always_comb begin
      priority if (dim_ff == '0) begin
         last_idx_in = '0;
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         last_idx_in = IDX_W'(MAX_DIM - 1);
      end else begin
         last_idx_in = IDX_W'(dim_ff - DIM_W'(1));
      end
   end

   // sequencer state
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] row_ff;
   logic [IDX_W-1:0] col_ff;
   logic [IDX_W-1:0] k_ff;
   logic [IDX_W-1:0] last_ff;
   logic             sum_rdy_ff;
   logic             slot_free;
   logic             emit;
   logic             issue;

   // output slot is free when empty or being drained this cycle
   assign slot_free  = !rsp_tvalid || rsp_tready;
   assign issue      = (state_ff == ST_RUN);
   assign emit       = (state_ff == ST_WAIT) && sum_rdy_ff && slot_free;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser == OP_COMPUTE && req_row <= last_idx_in) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (k_ff == last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (emit) begin
               state_in = (col_ff == last_ff) ? ST_IDLE : ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // row, column and inner index counters
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_xfer) begin
         row_ff  <= req_row;
         last_ff <= last_idx_in;
         col_ff  <= '0;
         k_ff    <= '0;
      end else if (issue) begin
         k_ff <= k_ff + IDX_W'(1);
      end else if (emit) begin
         col_ff <= col_ff + IDX_W'(1);
         k_ff   <= '0;
      end
   end

   // element memories, B stored transposed
   elem_type a_mem [DEPTH];
   elem_type b_mem [DEPTH];
   elem_type a_rd_ff;
   elem_type b_rd_ff;
   logic [ADDR_W-1:0] a_rd_addr;
   logic [ADDR_W-1:0] b_rd_addr;

   assign a_rd_addr = {row_ff, k_ff};
   assign b_rd_addr = {col_ff, k_ff};

   always_ff @(posedge clock) begin
      if (req_xfer && req_tuser == OP_LOAD_A) begin
         a_mem[{req_row, req_col}] <= req_value;
      end
      a_rd_ff <= a_mem[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_tuser == OP_LOAD_B) begin
         b_mem[{req_col, req_row}] <= req_value;
      end
      b_rd_ff <= b_mem[b_rd_addr];
   end

   // pipeline control: read, multiply, accumulate
   logic rd_vld_ff, rd_first_ff, rd_last_ff;
   logic prod_vld_ff, prod_first_ff, prod_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         sum_rdy_ff  <= 1'b0;
      end else begin
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         if (prod_vld_ff && prod_last_ff) begin
            sum_rdy_ff <= 1'b1;
         end else if (emit) begin
            sum_rdy_ff <= 1'b0;
         end
      end
   end

   // shared multiply-accumulate
   logic signed [PROD_W-1:0] prod_ff;
   acc_type                  acc_ff;

   always_ff @(posedge clock) begin
      rd_first_ff   <= (k_ff == '0);
      rd_last_ff    <= (k_ff == last_ff);
      prod_first_ff <= rd_first_ff;
      prod_last_ff  <= rd_last_ff;
      prod_ff       <= a_rd_ff * b_rd_ff;
      if (prod_vld_ff) begin
         acc_ff <= (prod_first_ff ? acc_type'(0) : acc_ff) + ACC_W'(prod_ff);
      end
   end

   // output register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {{(RSP_DATA_W - ACC_W - 2 * IDX_W){1'b0}}, acc_ff, col_ff, row_ff};
         rsp_last_ff <= (col_ff == last_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_CLK(a_idle_empty, clock, reset,
      (state_ff == ST_IDLE) |-> (!rd_vld_ff && !prod_vld_ff && !sum_rdy_ff),
      "request accepted with MAC pipeline busy")
   `ASSERT_CLK(a_sum_in_wait, clock, reset,
      sum_rdy_ff |-> (state_ff == ST_WAIT),
      "finished sum outside of wait state")
   `ASSERT_CLK(a_row_done, clock, reset,
      (emit && col_ff == last_ff) |=> (state_ff == ST_IDLE && rsp_tvalid && rsp_tlast),
      "last column did not end the row")

endmodule
